@@ rtl/core/plzd_pkg.sv @@
package plzd_pkg;

  localparam int OFFSET_BITS   = 12;
  localparam int HIST_DEPTH_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W  = 8;
  localparam int HDR_W   = 3;
  localparam int POS_W   = 16;
  localparam int START_W = OFFSET_BITS + 1;
  localparam int LEN_W   = 5;
  localparam int TOKEN_W = 16;
  localparam int LEN_SHIFT = TOKEN_W - OFFSET_BITS;

  localparam logic [BYTE_W-1:0] COMPRESSED_MARK = 8'h04;
  localparam logic [BYTE_W-1:0] REWRITTEN_MARK  = 8'h03;
  localparam logic [HDR_W-1:0]  HDR_RESET       = 3'd3;
  localparam logic [LEN_W-1:0]  LEN_BIAS        = 5'd2;
  localparam logic [2:0]        LAST_ITEM       = 3'd7;

  // word kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_PASS,   // passthrough byte, not stored
    CMD_STORE,  // byte that goes out and into history
    CMD_COPY,   // back-reference copy
    CMD_MARK    // end marker only
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   data;
    logic                new_pkt;     // rewind output position first
    logic                last;        // passthrough last byte
    logic                mark_after;  // end marker follows this command
    logic                trunc;       // truncated flag for that marker
    logic [START_W-1:0]  start;       // copy source, 1-based position
    logic [LEN_W-1:0]    len;         // copy length, 2..17
  } cmd_t;

  function automatic logic [HDR_W-1:0] eff_header(input logic [HDR_W-1:0] h);
    eff_header = (h == '0) ? HDR_W'(1) : h;
  endfunction

endpackage

@@ rtl/core/plzd_front.sv @@
module plzd_front
  import plzd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HDR_W-1:0]  header_length,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_first,
  input  logic              in_last,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  typedef enum logic [2:0] {F_IDLE, F_PASS, F_HDR, F_GRP, F_TOK} fphase_t;

  fphase_t           phase_r, phase_nxt;
  logic [HDR_W-1:0]  hdr_left_r, hdr_left_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [3:0]        bit_idx_r, bit_idx_nxt;
  logic [7:0]        tok_low_r, tok_low_nxt;

  logic                accept;
  logic [HDR_W-1:0]    h_eff;
  logic [HDR_W-1:0]    hl_dec;
  logic [TOKEN_W-1:0]  token;
  logic [OFFSET_BITS-1:0] offset;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign h_eff    = eff_header(header_length);
  assign token    = {in_byte, tok_low_r};
  assign offset   = token[TOKEN_W-1:LEN_SHIFT];

  always_comb begin
    phase_nxt    = phase_r;
    hdr_left_nxt = hdr_left_r;
    flags_nxt    = flags_r;
    bit_idx_nxt  = bit_idx_r;
    tok_low_nxt  = tok_low_r;
    hl_dec       = hdr_left_r - HDR_W'(1);
    push         = 1'b0;
    push_cmd     = '0;
    push_cmd.kind = CMD_MARK;
    push_cmd.data = in_byte;
    push_cmd.start = START_W'(offset) + START_W'(h_eff);
    push_cmd.len   = LEN_W'(token[3:0]) + LEN_BIAS;

    if (accept) begin
      if (in_first) begin
        flags_nxt   = '0;
        bit_idx_nxt = 4'd8;
        tok_low_nxt = '0;
        push        = 1'b1;
        if (in_byte != COMPRESSED_MARK) begin
          push_cmd.kind = CMD_PASS;
          push_cmd.last = in_last;
          hdr_left_nxt  = '0;
          phase_nxt     = in_last ? F_IDLE : F_PASS;
        end else begin
          push_cmd.kind       = CMD_STORE;
          push_cmd.data       = REWRITTEN_MARK;
          push_cmd.new_pkt    = 1'b1;
          push_cmd.mark_after = in_last;
          push_cmd.trunc      = (h_eff != HDR_W'(1));
          hdr_left_nxt        = h_eff - HDR_W'(1);
          if (in_last) begin
            phase_nxt = F_IDLE;
          end else begin
            phase_nxt = (h_eff != HDR_W'(1)) ? F_HDR : F_GRP;
          end
        end
      end else begin
        case (phase_r)
          F_PASS: begin
            push          = 1'b1;
            push_cmd.kind = CMD_PASS;
            push_cmd.last = in_last;
            if (in_last) phase_nxt = F_IDLE;
          end
          F_HDR: begin
            push                = 1'b1;
            push_cmd.kind       = CMD_STORE;
            push_cmd.mark_after = in_last;
            push_cmd.trunc      = (hl_dec != '0);
            hdr_left_nxt        = hl_dec;
            if (in_last) begin
              phase_nxt = F_IDLE;
            end else if (hl_dec == '0) begin
              phase_nxt = F_GRP;
            end
          end
          F_GRP: begin
            if (bit_idx_r[3]) begin
              // flag byte opens a group
              flags_nxt   = in_byte;
              bit_idx_nxt = '0;
              if (in_last) begin
                push           = 1'b1;
                push_cmd.kind  = CMD_MARK;
                push_cmd.trunc = 1'b1;
                phase_nxt      = F_IDLE;
              end
            end else if (!flags_r[bit_idx_r[2:0]]) begin
              push                = 1'b1;
              push_cmd.kind       = CMD_STORE;
              push_cmd.mark_after = in_last;
              push_cmd.trunc      = (bit_idx_r[2:0] != LAST_ITEM);
              bit_idx_nxt         = bit_idx_r + 4'd1;
              if (in_last) phase_nxt = F_IDLE;
            end else begin
              tok_low_nxt = in_byte;
              phase_nxt   = F_TOK;
              if (in_last) begin
                push           = 1'b1;
                push_cmd.kind  = CMD_MARK;
                push_cmd.trunc = 1'b1;
                phase_nxt      = F_IDLE;
              end
            end
          end
          F_TOK: begin
            push = 1'b1;
            if (offset == '0) begin
              // end token
              push_cmd.kind  = CMD_MARK;
              push_cmd.trunc = 1'b0;
              phase_nxt      = F_IDLE;
            end else begin
              push_cmd.kind       = CMD_COPY;
              push_cmd.mark_after = in_last;
              push_cmd.trunc      = (bit_idx_r[2:0] != LAST_ITEM);
              bit_idx_nxt         = bit_idx_r + 4'd1;
              phase_nxt           = in_last ? F_IDLE : F_GRP;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= F_IDLE;
      hdr_left_r <= '0;
      flags_r    <= '0;
      bit_idx_r  <= 4'd8;
      tok_low_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_left_r <= hdr_left_nxt;
      flags_r    <= flags_nxt;
      bit_idx_r  <= bit_idx_nxt;
      tok_low_r  <= tok_low_nxt;
    end
  end

endmodule

@@ rtl/core/plzd_queue.sv @@
module plzd_queue
  import plzd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/plzd_back.sv @@
module plzd_back
  import plzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_data,
  output logic              out_trunc,
  output logic              out_last,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [POS_W:0] DEPTH_L = (POS_W + 1)'(HISTORY_DEPTH);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {B_FETCH, B_EMIT, B_RD, B_CEMIT, B_MARK} bstate_t;

  bstate_t           state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  cp_pos_r, cp_pos_nxt;
  logic [LEN_W-1:0]  cp_len_r, cp_len_nxt;
  logic              zero_r, zero_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_is_data_r, out_is_data_nxt;
  logic              out_trunc_r, out_trunc_nxt;
  logic              out_last_r, out_last_nxt;

  logic [BYTE_W-1:0] hist [HISTORY_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              slot_free;
  logic              src_ok;
  logic [POS_W-1:0]  src_idx;

  assign slot_free = !out_valid_r || out_ready;
  assign src_idx   = cp_pos_r - POS_W'(1);
  // source counts only if already written in this packet and inside the store
  assign src_ok    = (cp_pos_r <= pos_r) && ({1'b0, src_idx} < DEPTH_L);
  assign rd_addr   = AW'(src_idx);
  assign wr_addr   = AW'(pos_r);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    pos_nxt         = pos_r;
    cp_pos_nxt      = cp_pos_r;
    cp_len_nxt      = cp_len_r;
    zero_nxt        = zero_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_byte_nxt    = out_byte_r;
    out_is_data_nxt = out_is_data_r;
    out_trunc_nxt   = out_trunc_r;
    out_last_nxt    = out_last_r;
    pop             = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_data         = cmd_r.data;

    case (state_r)
      B_FETCH: begin
        if (!q_empty) begin
          pop        = 1'b1;
          cmd_nxt    = q_head;
          cp_pos_nxt = POS_W'(q_head.start);
          cp_len_nxt = q_head.len;
          if (q_head.new_pkt) pos_nxt = '0;
          case (q_head.kind)
            CMD_COPY: state_nxt = B_RD;
            CMD_MARK: state_nxt = B_MARK;
            default:  state_nxt = B_EMIT;
          endcase
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = cmd_r.data;
          out_is_data_nxt = 1'b1;
          out_trunc_nxt   = 1'b0;
          out_last_nxt    = (cmd_r.kind == CMD_PASS) && cmd_r.last;
          if (cmd_r.kind == CMD_STORE) begin
            wr_en   = ({1'b0, pos_r} < DEPTH_L);
            pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
          end
          state_nxt = cmd_r.mark_after ? B_MARK : B_FETCH;
        end
      end
      B_RD: begin
        rd_en     = src_ok;
        zero_nxt  = !src_ok;
        state_nxt = B_CEMIT;
      end
      B_CEMIT: begin
        if (slot_free) begin
          wr_data         = zero_r ? '0 : rd_data_r;
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = wr_data;
          out_is_data_nxt = 1'b1;
          out_trunc_nxt   = 1'b0;
          out_last_nxt    = 1'b0;
          wr_en           = ({1'b0, pos_r} < DEPTH_L);
          pos_nxt         = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
          cp_pos_nxt      = cp_pos_r + POS_W'(1);
          cp_len_nxt      = cp_len_r - LEN_W'(1);
          if (cp_len_r == LEN_W'(1)) begin
            state_nxt = cmd_r.mark_after ? B_MARK : B_FETCH;
          end else begin
            state_nxt = B_RD;
          end
        end
      end
      B_MARK: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = '0;
          out_is_data_nxt = 1'b0;
          out_trunc_nxt   = cmd_r.trunc;
          out_last_nxt    = 1'b1;
          state_nxt       = B_FETCH;
        end
      end
      default: begin
        state_nxt = B_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_FETCH;
      pos_r       <= '0;
      cp_len_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cp_len_r    <= cp_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    cp_pos_r      <= cp_pos_nxt;
    zero_r        <= zero_nxt;
    out_byte_r    <= out_byte_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_trunc_r   <= out_trunc_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_trunc   = out_trunc_r;
  assign out_last    = out_last_r;

endmodule

@@ rtl/core/packet_lz_decompressor_unit.sv @@
// Path: a literal, header or passthrough word passes the front end, the command queue,
//   B_FETCH and B_EMIT; a copy token passes B_FETCH, then B_RD and B_CEMIT per byte.
// The back end works on one queued word at a time; a copy emits len+2 bytes,
//   a trailing end marker follows in B_MARK; a 4-word command queue absorbs bursts
//   at 1 word/cycle while it is not full (in_tready low when full).
// Reset (rst_n, synchronous): control cleared, header_length back to 3, history kept.
module packet_lz_decompressor_unit
  import plzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // config: header_length
  input  logic             cfg_wr_en,
  input  logic [HDR_W-1:0] cfg_wr_data,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] byte_in
  input  logic             in_tuser,   // [0] first
  input  logic             in_tlast,   // last
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] byte_out
  output logic [1:0]       out_tuser,  // [0] is_data, [1] truncated
  output logic             out_tlast   // last_out
);

  logic [HDR_W-1:0] header_length_r;

  // front -> queue -> back
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_push_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_length_r <= HDR_RESET;
    end else if (cfg_wr_en) begin
      header_length_r <= cfg_wr_data;
    end
  end

  // parser: header count, flag bits, token assembly; at most one command per word
  plzd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .header_length (header_length_r),
    .in_byte       (in_tdata),
    .in_first      (in_tuser),
    .in_last       (in_tlast),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (q_push_cmd)
  );

  plzd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // sequencer: output position, history store, copy loop, output register
  plzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_byte    (out_tdata),
    .out_is_data (out_tuser[0]),
    .out_trunc   (out_tuser[1]),
    .out_last    (out_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready)
  );

endmodule

@@ tb/packet_lz_decompressor_unit_test.sv @@
module packet_lz_decompressor_unit_test;
  import plzd_pkg::*;

  localparam int HIST_WORDS    = HIST_DEPTH_DEF;
  localparam int HIST_AW       = $clog2(HIST_WORDS);
  localparam int GROUP_SIZE    = 8;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 20;    // quiet time before a register write / the end
  localparam int MAX_SHOWN     = 40;
  localparam int PHASE_ITEMS   = 60;
  localparam logic [15:0] POS_MAX         = 16'hFFFF;
  localparam logic [7:0]  FLAG_ALL_TOKENS = 8'hFF;
  localparam logic [7:0]  FLAG_ALL_LITS   = 8'h00;
  localparam logic [3:0]  LEN_MAX         = 4'hF;

  // parser position, mirrors the front end of the block
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_PASS,
    PS_HEADER,
    PS_GROUP,
    PS_TOKEN
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       trunc;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
  } pkt_byte_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [HDR_W-1:0] cfg_wr_data = HDR_RESET;
  logic             in_tvalid   = 1'b0;
  logic [7:0]       in_tdata    = '0;
  logic             in_tuser    = 1'b0;
  logic             in_tlast    = 1'b0;
  logic             out_tready  = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [7:0]       out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  packet_lz_decompressor_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [7:0] byte_in
    .in_tuser    (in_tuser),     // [0] first
    .in_tlast    (in_tlast),     // last
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [7:0] byte_out
    .out_tuser   (out_tuser),    // [0] is_data, [1] truncated
    .out_tlast   (out_tlast)     // last_out
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decompressor prediction state
  // ---------------------------------------------------------------------------
  logic [HDR_W-1:0] hdr_len = HDR_RESET;
  parse_state_t     ps      = PS_IDLE;
  logic [2:0]       hdr_left;
  logic [7:0]       flag_byte;
  int               item_idx = GROUP_SIZE;
  logic [7:0]       tok_low;
  logic [15:0]      out_pos  = '0;
  logic [7:0]       hist_mem [0:HIST_WORDS-1];

  out_word_t expected_words[$];
  pkt_byte_t pkt_bytes[$];

  int  errors = 0;
  int  shown  = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  rx_wait = 0;
  int  rx_hold = 0;
  int  quiet_cycles = 0;

  // header length 0 behaves as 1
  function automatic int hdr_eff();
    return (hdr_len == '0) ? 1 : int'(hdr_len);
  endfunction

  // data word of a compressed packet: goes out and into history
  function automatic void store_byte(logic [7:0] v);
    if (out_pos < HIST_WORDS) hist_mem[HIST_AW'(out_pos)] = v;
    if (out_pos != POS_MAX) out_pos++;
    expected_words.insert(expected_words.size(), out_word_t'{v, 1'b1, 1'b0, 1'b0});
  endfunction

  function automatic void close_packet(logic t);
    ps = PS_IDLE;
    expected_words.insert(expected_words.size(), out_word_t'{8'h00, 1'b0, t, 1'b1});
  endfunction

  // advance the parser by one accepted input word
  function automatic void decode_word(logic [7:0] b, logic f, logic l);
    logic [15:0] tok;
    int          src_pos;
    int          span;
    logic [7:0]  v;
    if (f) begin
      out_pos   = '0;
      item_idx  = GROUP_SIZE;
      flag_byte = '0;
      tok_low   = '0;
      hdr_left  = '0;
      if (b != COMPRESSED_MARK) begin
        ps = l ? PS_IDLE : PS_PASS;
        expected_words.insert(expected_words.size(), out_word_t'{b, 1'b1, 1'b0, l});
      end else begin
        store_byte(REWRITTEN_MARK);
        hdr_left = 3'(hdr_eff() - 1);
        ps = (hdr_left != '0) ? PS_HEADER : PS_GROUP;
        if (l) close_packet(hdr_left != '0);
      end
      return;
    end
    case (ps)
      PS_PASS: begin
        expected_words.insert(expected_words.size(), out_word_t'{b, 1'b1, 1'b0, l});
        if (l) ps = PS_IDLE;
      end
      PS_HEADER: begin
        store_byte(b);
        hdr_left--;
        if (hdr_left == '0) ps = PS_GROUP;
        if (l) close_packet(hdr_left != '0);
      end
      PS_GROUP: begin
        if (item_idx >= GROUP_SIZE) begin
          flag_byte = b;
          item_idx  = 0;
          if (l) close_packet(1'b1);
        end else if (!flag_byte[3'(item_idx)]) begin
          store_byte(b);
          item_idx++;
          if (l) close_packet(item_idx < GROUP_SIZE);
        end else begin
          tok_low = b;
          ps      = PS_TOKEN;
          if (l) close_packet(1'b1);
        end
      end
      PS_TOKEN: begin
        tok = {b, tok_low};
        if (tok[15:LEN_SHIFT] == '0) begin
          close_packet(1'b0);
        end else begin
          span    = int'(tok[3:0]) + 2;
          src_pos = int'(tok[15:LEN_SHIFT]) + hdr_eff();
          // byte by byte, so a copy can read what it just wrote
          for (int p = src_pos; p < src_pos + span; p++) begin
            v = (p <= int'(out_pos) && p - 1 < HIST_WORDS) ?
                hist_mem[HIST_AW'(p - 1)] : 8'h00;
            store_byte(v);
          end
          item_idx++;
          ps = PS_GROUP;
          if (l) close_packet(item_idx < GROUP_SIZE);
        end
      end
      default: ;  // idle: stray word dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void note_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got && shown < MAX_SHOWN) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      shown++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_word_t'{out_tdata, out_tuser[0], out_tuser[1], out_tlast};
      if (expected_words.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          $display("%0t: word expected none got %h", $time, got);
          shown++;
        end
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          errors++;
          note_field("byte_out", want.data, got.data);
          note_field("is_data", 8'(want.is_data), 8'(got.is_data));
          note_field("truncated", 8'(want.trunc), 8'(got.trunc));
          note_field("last_out", 8'(want.last), 8'(got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random wait per word in idle phases, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        rx_hold  = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (out_tvalid && out_tready) rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run if no word moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  // offer one word; valid stays high afterwards unless the next call idles
  task automatic send_word(input logic [7:0] b, input logic f, input logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_word(b, f, l);
  endtask

  // wait out every expected word plus the tail of the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [HDR_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    hdr_len = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] d, logic f);
    pkt_bytes.insert(pkt_bytes.size(), pkt_byte_t'{d, f, 1'b0});
  endfunction

  function automatic logic [7:0] pass_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == COMPRESSED_MARK) ? ~b : b;
  endfunction

  task automatic send_pkt_bytes();
    foreach (pkt_bytes[i]) send_word(pkt_bytes[i].data, pkt_bytes[i].is_first,
                                     pkt_bytes[i].is_last);
  endtask

  // well-formed compressed packet with random content; ends on an end token,
  // cleanly on a group boundary, or cut short (sometimes with no last at all)
  task automatic make_compressed_packet();
    int         groups;
    int         ending;
    int         stop_at;
    int         produced;
    int         hi;
    logic [7:0] flag;
    logic [11:0] off;
    logic [3:0] len;
    pkt_bytes.delete();
    ending = $urandom_range(0, 9);
    add_byte(COMPRESSED_MARK, 1'b1);
    for (int i = 1; i < hdr_eff(); i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    produced = hdr_eff();
    groups = $urandom_range(ending < 4 ? 1 : 0, 3);
    for (int g = 0; g < groups; g++) begin
      flag = 8'($urandom_range(0, 255));
      stop_at = (ending < 4 && g == groups - 1) ? $urandom_range(0, 7) : GROUP_SIZE;
      if (stop_at < GROUP_SIZE) flag[3'(stop_at)] = 1'b1;
      add_byte(flag, 1'b0);
      for (int k = 0; k < GROUP_SIZE && k <= stop_at; k++) begin
        if (k == stop_at) begin
          // zero offset ends the packet; length bits are don't-care
          add_byte(8'($urandom_range(0, 15)), 1'b0);
          add_byte(8'h00, 1'b0);
        end else if (!flag[3'(k)]) begin
          add_byte(8'($urandom_range(0, 255)), 1'b0);
          produced++;
        end else begin
          // mostly reach back into what was written, sometimes anywhere
          hi = produced - hdr_eff() + 2;
          if (hi > 4095) hi = 4095;
          off = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095)) :
                                              12'($urandom_range(1, hi));
          len = 4'($urandom_range(0, 15));
          add_byte({off[3:0], len}, 1'b0);
          add_byte(off[11:4], 1'b0);
          produced += int'(len) + 2;
        end
      end
    end
    // stray words after an end token are dropped by the block
    if (ending < 4) repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    if (ending >= 7) begin
      if (ending == 9 && $urandom_range(0, 1) == 1) return;  // next first cuts it off
      hi = $urandom_range(0, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > hi + 1) void'(pkt_bytes.pop_back());
    end
    pkt_bytes[$].is_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    settle();
    cfg_write(3'd1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // passthrough packet, byte extremes
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h55, 1'b0, 1'b1);
    // words with no packet open are dropped
    send_word(8'hAA, 1'b0, 1'b0);
    send_word(COMPRESSED_MARK, 1'b0, 1'b1);
    // literal, overlapping two-byte copy, then end token
    send_word(COMPRESSED_MARK, 1'b1, 1'b0);
    send_word(8'h06, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h10, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h0F, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    // input runs out right after a flag word
    send_word(COMPRESSED_MARK, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // new packet starts while one is open: no marker for the dropped one
    send_word(COMPRESSED_MARK, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h11, 1'b1, 1'b1);
    // compressed packet that is only its one header byte: clean end
    send_word(COMPRESSED_MARK, 1'b1, 1'b1);
    settle();
    cfg_write(3'd7);
    // header cut short
    send_word(COMPRESSED_MARK, 1'b1, 1'b0);
    send_word(8'h01, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b1);
  endtask

  // receiver holds off while literals pour in, so the queue fills and
  // in_tready drops; then the sender waits for everything to drain
  task automatic test_backpressure();
    settle();
    cfg_write(3'd2);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    pkt_bytes.delete();
    add_byte(COMPRESSED_MARK, 1'b1);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat (3) begin
      add_byte(FLAG_ALL_LITS, 1'b0);
      repeat (GROUP_SIZE) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    pkt_bytes[$].is_last = 1'b1;
    send_pkt_bytes();
    settle();
  endtask

  task automatic run_random_phase(input logic [HDR_W-1:0] hdr, input bit idle);
    int sent;
    int pick;
    settle();
    cfg_write(hdr);
    tx_idle = idle;
    rx_idle = idle;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      pkt_bytes.delete();
      if (pick < 2) begin
        add_byte(pass_byte(), 1'b1);
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        pkt_bytes[$].is_last = 1'b1;
        sent += pkt_bytes.size();
      end else if (pick == 2) begin
        // noise: random flags, mostly dropped or broken packets
        repeat ($urandom_range(1, 4)) begin
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          pkt_bytes[$].is_last = ($urandom_range(0, 3) == 0);
        end
      end else begin
        make_compressed_packet();
        sent += pkt_bytes.size();
      end
      send_pkt_bytes();
    end
    // one-word passthrough packet leaves the parser idle for the next write
    send_word(pass_byte(), 1'b1, 1'b1);
  endtask

  task automatic test_random_packets();
    run_random_phase(3'd7, 1'b0);
    run_random_phase(3'd1, 1'b1);
    run_random_phase(3'($urandom_range(1, 7)), 1'b1);
    run_random_phase(3'($urandom_range(1, 7)), 1'b1);
    run_random_phase(HDR_RESET, 1'b1);
  endtask

  // two groups of maximal-length copies, 17 output bytes per token word pair
  task automatic test_long_copies();
    logic [11:0] off;
    settle();
    cfg_write(3'd1);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    send_word(COMPRESSED_MARK, 1'b1, 1'b0);
    for (int g = 0; g < 2; g++) begin
      send_word(FLAG_ALL_TOKENS, 1'b0, 1'b0);
      for (int k = 0; k < GROUP_SIZE; k++) begin
        off = 12'($urandom_range(1, 4095));
        send_word({off[3:0], LEN_MAX}, 1'b0, 1'b0);
        send_word(off[11:4], 1'b0, g == 1 && k == GROUP_SIZE - 1);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_backpressure();
    test_random_packets();
    test_long_copies();
    settle();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ packet_lz_decompressor_unit.f @@
rtl/core/plzd_pkg.sv
rtl/core/plzd_front.sv
rtl/core/plzd_queue.sv
rtl/core/plzd_back.sv
rtl/core/packet_lz_decompressor_unit.sv
tb/packet_lz_decompressor_unit_test.sv
